// ----- rtl/core/geodetic_to_ecef_top_assert.svh -----
// Assertion macros for the geodetic to ECEF block.
// Both sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef GEODETIC_TO_ECEF_TOP_ASSERT_SVH
`define GEODETIC_TO_ECEF_TOP_ASSERT_SVH

// Same-cycle implication.
`define GTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gte: same-cycle check failed");

// Next-cycle implication.
`define GTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gte: next-cycle check failed");

`endif

// ----- rtl/core/gte_pkg.sv -----
// ----------------------------------------------------------------------------
// gte_pkg
// Types, fixed-point constants and the CORDIC angle table of the block.
// ----------------------------------------------------------------------------
package gte_pkg;

  // Working word: Q30 values with headroom.
  typedef logic signed [33:0] q_t;
  typedef logic signed [67:0] prod_t;

  localparam q_t   Q30_ONE          = 34'sd1073741824;
  localparam q_t   THREE_Q30        = 34'sd3221225472;
  localparam q_t   CORDIC_GAIN_Q30  = 34'sd652032874;
  localparam q_t   E2_Q30           = 34'sd7188035;
  localparam q_t   ONE_MINUS_E2_Q30 = 34'sd1066553789;
  localparam q_t   SEMI_MAJOR_M     = 34'sd6378137;
  localparam prod_t DEG2RAD_Q32     = 68'sd74961321;
  localparam logic signed [31:0] OUT_LIMIT = 32'sd1632803072;

  // Remainder by 45: q = (v * MOD45_MUL) >> MOD45_SHIFT, low by at most one.
  localparam int unsigned MOD45_SHIFT = 26;
  localparam logic [20:0] MOD45_MUL   = 21'd1491309;
  localparam int unsigned MOD45_MULW  = 21;

  localparam q_t ATAN_HEAD [10] = '{
    34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6, 34'sh003FEAB76,
    34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55, 34'sh0003FFFEA, 34'sh0001FFFFD
  };

  // atan(2^-i) in Q30.
  function automatic q_t atan_q30(int unsigned i);
    q_t one;
    one = 34'sd1;
    if (i < 10) begin
      return ATAN_HEAD[i];
    end else if (i <= 30) begin
      return one <<< (30 - i);
    end
    return '0;
  endfunction

  function automatic prod_t mul(q_t a, q_t b);
    return 68'(a) * 68'(b);
  endfunction

  // Shift right by s (s >= 1), rounding half up.
  function automatic q_t rnd(prod_t p, int unsigned s);
    prod_t t;
    t = (p + (68'sd1 <<< (s - 1))) >>> s;
    return t[33:0];
  endfunction

  function automatic logic signed [31:0] sat_out(q_t v);
    if (v > 34'(OUT_LIMIT)) begin
      return OUT_LIMIT;
    end else if (v < -34'(OUT_LIMIT)) begin
      return -OUT_LIMIT;
    end
    return v[31:0];
  endfunction

endpackage

// ----- rtl/core/geodetic_to_ecef_top.sv -----
// Throughput: one transaction per cycle; the whole pipeline advances together and
//   holds only while a result sits in the output register with out_stall_i high.
// Reset clears all valid bits at once; data registers are not reset.
// Depth is set by one CORDIC stage per iteration and two unrolled Newton steps.
// ----------------------------------------------------------------------------
// geodetic_to_ecef_top
// WGS84 geodetic (height zero) to ECEF X/Y/Z, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module geodetic_to_ecef_top #(
  parameter int unsigned ANGLE_FRAC_BITS = 24,
  parameter int unsigned CORDIC_STAGES   = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [32:0] lon_deg_i,
  input  logic signed [31:0] lat_deg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_m_o,
  output logic signed [31:0] y_m_o,
  output logic signed [31:0] z_m_o
);
  import gte_pkg::*;

  localparam int unsigned NS  = CORDIC_STAGES;
  localparam int unsigned LAT = NS + 15;
  // Angle word after wrapping: covers +-360 degrees.
  localparam int unsigned AW  = ANGLE_FRAC_BITS + 10;
  // 360 deg = 45 * 2^LSH, so wrapping is a remainder by 45 on the high part.
  localparam int unsigned LSH = ANGLE_FRAC_BITS + 3;
  localparam int unsigned HW  = 33 - LSH;
  localparam int unsigned HPW = HW + 6;
  localparam int unsigned QW  = HW + 1;
  localparam logic [HPW-1:0] HOFS = HPW'(45 * (64'd1 << (HW - 1)));
  localparam int unsigned LSW = ((AW > 32) ? AW : 32) + 1;

  localparam logic signed [AW-1:0]  FULL    = AW'(64'sd360 <<< ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0]  HALF    = AW'(64'sd180 <<< ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0]  QUARTER = AW'(64'sd90 <<< ANGLE_FRAC_BITS);
  localparam logic signed [LSW-1:0] QUARTER_L = LSW'(64'sd90 <<< ANGLE_FRAC_BITS);

  // Global advance: everything moves unless the output is held.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Stage A: input register.
  logic signed [32:0] a_lon_q;
  logic signed [31:0] a_lat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_lon_q <= lon_deg_i;
      a_lat_q <= lat_deg_i;
    end
  end

  // Stage B: quotient estimate of the high part by 45, latitude clamp.
  logic signed [32:0]      b_hi;
  logic signed [HW-1:0]    b_h;
  logic signed [HPW:0]     b_hp_s;
  logic [HPW-1:0]          b_hp;
  logic [HPW+MOD45_MULW-1:0] b_prod;
  logic signed [LSW-1:0]   b_lat_x;
  logic signed [LSW-1:0]   b_lat_s;
  logic [HPW-1:0]          b_hp_q;
  logic [QW-1:0]           b_quo_q;
  logic [LSH-1:0]          b_low_q;
  logic signed [AW-1:0]    b_lat_q;

  always_comb begin
    b_hi    = a_lon_q >>> LSH;
    b_h     = b_hi[HW-1:0];
    b_hp_s  = (HPW+1)'(b_h) + $signed({1'b0, HOFS});
    b_hp    = b_hp_s[HPW-1:0];
    b_prod  = (HPW+MOD45_MULW)'(b_hp) * (HPW+MOD45_MULW)'(MOD45_MUL);
    b_lat_x = LSW'(a_lat_q);
    priority if (b_lat_x > QUARTER_L) begin
      b_lat_s = QUARTER_L;
    end else if (b_lat_x < -QUARTER_L) begin
      b_lat_s = -QUARTER_L;
    end else begin
      b_lat_s = b_lat_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_hp_q  <= b_hp;
      b_quo_q <= QW'(b_prod >> MOD45_SHIFT);
      b_low_q <= a_lon_q[LSH-1:0];
      b_lat_q <= b_lat_s[AW-1:0];
    end
  end

  // Stage C: remainder, wrap into [-180, 180), fold into [-90, 90].
  logic [HPW-1:0]         c_rem;
  logic [HPW-1:0]         c_remc;
  logic [LSH+5:0]         c_lonm;
  logic signed [AW-1:0]   c_lw;
  logic signed [AW-1:0]   c_lh;
  logic signed [AW-1:0]   c_lf;
  logic                   c_flip;
  logic signed [AW-1:0]   c_lon_q;
  logic signed [AW-1:0]   c_lat_q;
  logic                   c_flip_q;

  always_comb begin
    c_rem  = b_hp_q - HPW'(HPW'(b_quo_q) * HPW'(45));
    c_remc = (c_rem >= HPW'(45)) ? (c_rem - HPW'(45)) : c_rem;
    c_lonm = {c_remc[5:0], b_low_q};
    c_lw   = $signed({1'b0, c_lonm});
    c_lh   = (c_lw >= HALF) ? (c_lw - FULL) : c_lw;
    c_flip = 1'b0;
    priority if (c_lh > QUARTER) begin
      c_lf   = HALF - c_lh;
      c_flip = 1'b1;
    end else if (c_lh < -QUARTER) begin
      c_lf   = -HALF - c_lh;
      c_flip = 1'b1;
    end else begin
      c_lf   = c_lh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_lon_q  <= c_lf;
      c_lat_q  <= b_lat_q;
      c_flip_q <= c_flip;
    end
  end

  // Stage D: degrees to Q30 radians, CORDIC start vectors.
  q_t   xl_q [NS+1];
  q_t   yl_q [NS+1];
  q_t   zl_q [NS+1];
  q_t   xt_q [NS+1];
  q_t   yt_q [NS+1];
  q_t   zt_q [NS+1];
  logic fl_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xl_q[0] <= CORDIC_GAIN_Q30;
      yl_q[0] <= '0;
      zl_q[0] <= rnd(68'(c_lon_q) * DEG2RAD_Q32, ANGLE_FRAC_BITS + 2);
      xt_q[0] <= CORDIC_GAIN_Q30;
      yt_q[0] <= '0;
      zt_q[0] <= rnd(68'(c_lat_q) * DEG2RAD_Q32, ANGLE_FRAC_BITS + 2);
      fl_q[0] <= c_flip_q;
    end
  end

  // CORDIC rotation, one iteration per stage, lon and lat side by side.
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam q_t ATAN = atan_q30(i);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (zl_q[i] >= 0) begin
          xl_q[i+1] <= xl_q[i] - (yl_q[i] >>> i);
          yl_q[i+1] <= yl_q[i] + (xl_q[i] >>> i);
          zl_q[i+1] <= zl_q[i] - ATAN;
        end else begin
          xl_q[i+1] <= xl_q[i] + (yl_q[i] >>> i);
          yl_q[i+1] <= yl_q[i] - (xl_q[i] >>> i);
          zl_q[i+1] <= zl_q[i] + ATAN;
        end
        if (zt_q[i] >= 0) begin
          xt_q[i+1] <= xt_q[i] - (yt_q[i] >>> i);
          yt_q[i+1] <= yt_q[i] + (xt_q[i] >>> i);
          zt_q[i+1] <= zt_q[i] - ATAN;
        end else begin
          xt_q[i+1] <= xt_q[i] + (yt_q[i] >>> i);
          yt_q[i+1] <= yt_q[i] - (xt_q[i] >>> i);
          zt_q[i+1] <= zt_q[i] + ATAN;
        end
        fl_q[i+1] <= fl_q[i];
      end
    end
  end

  // Post stages: sin^2, radius via two Newton steps, products, saturation.
  q_t clon_f;
  q_t p3_r0;
  q_t p1_s2_q, p1_cx_q, p1_cy_q, p1_sl_q;
  q_t p2_u_q, p2_cx_q, p2_cy_q, p2_sl_q;
  q_t p3_w_q, p3_r_q, p3_t_q, p3_cx_q, p3_cy_q, p3_sl_q;
  q_t p4_w_q, p4_r_q, p4_t_q, p4_cx_q, p4_cy_q, p4_sl_q;
  q_t p5_w_q, p5_r_q, p5_cx_q, p5_cy_q, p5_sl_q;
  q_t p6_w_q, p6_r_q, p6_t_q, p6_cx_q, p6_cy_q, p6_sl_q;
  q_t p7_r_q, p7_t_q, p7_cx_q, p7_cy_q, p7_sl_q;
  q_t p8_r_q, p8_cx_q, p8_cy_q, p8_sl_q;
  q_t p9_n_q, p9_cx_q, p9_cy_q, p9_sl_q;
  q_t p10_x_q, p10_y_q, p10_nb_q, p10_sl_q;
  logic signed [31:0] x_q, y_q, z_q;

  assign clon_f = fl_q[NS] ? -xl_q[NS] : xl_q[NS];
  assign p3_r0  = Q30_ONE + (p2_u_q >>> 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_s2_q  <= rnd(mul(yt_q[NS], yt_q[NS]), 30);
      p1_cx_q  <= rnd(mul(xt_q[NS], clon_f), 30);
      p1_cy_q  <= rnd(mul(xt_q[NS], yl_q[NS]), 30);
      p1_sl_q  <= yt_q[NS];

      p2_u_q   <= rnd(mul(E2_Q30, p1_s2_q), 30);
      p2_cx_q  <= p1_cx_q;
      p2_cy_q  <= p1_cy_q;
      p2_sl_q  <= p1_sl_q;

      p3_w_q   <= Q30_ONE - p2_u_q;
      p3_r_q   <= p3_r0;
      p3_t_q   <= rnd(mul(p3_r0, p3_r0), 30);
      p3_cx_q  <= p2_cx_q;
      p3_cy_q  <= p2_cy_q;
      p3_sl_q  <= p2_sl_q;

      p4_w_q   <= p3_w_q;
      p4_r_q   <= p3_r_q;
      p4_t_q   <= rnd(mul(p3_w_q, p3_t_q), 30);
      p4_cx_q  <= p3_cx_q;
      p4_cy_q  <= p3_cy_q;
      p4_sl_q  <= p3_sl_q;

      p5_w_q   <= p4_w_q;
      p5_r_q   <= rnd(mul(p4_r_q, THREE_Q30 - p4_t_q), 31);
      p5_cx_q  <= p4_cx_q;
      p5_cy_q  <= p4_cy_q;
      p5_sl_q  <= p4_sl_q;

      p6_w_q   <= p5_w_q;
      p6_r_q   <= p5_r_q;
      p6_t_q   <= rnd(mul(p5_r_q, p5_r_q), 30);
      p6_cx_q  <= p5_cx_q;
      p6_cy_q  <= p5_cy_q;
      p6_sl_q  <= p5_sl_q;

      p7_r_q   <= p6_r_q;
      p7_t_q   <= rnd(mul(p6_w_q, p6_t_q), 30);
      p7_cx_q  <= p6_cx_q;
      p7_cy_q  <= p6_cy_q;
      p7_sl_q  <= p6_sl_q;

      p8_r_q   <= rnd(mul(p7_r_q, THREE_Q30 - p7_t_q), 31);
      p8_cx_q  <= p7_cx_q;
      p8_cy_q  <= p7_cy_q;
      p8_sl_q  <= p7_sl_q;

      // Prime-vertical radius, metres * 2^8.
      p9_n_q   <= rnd(mul(SEMI_MAJOR_M, p8_r_q), 22);
      p9_cx_q  <= p8_cx_q;
      p9_cy_q  <= p8_cy_q;
      p9_sl_q  <= p8_sl_q;

      p10_x_q  <= rnd(mul(p9_n_q, p9_cx_q), 30);
      p10_y_q  <= rnd(mul(p9_n_q, p9_cy_q), 30);
      p10_nb_q <= rnd(mul(p9_n_q, ONE_MINUS_E2_Q30), 30);
      p10_sl_q <= p9_sl_q;

      // Output register.
      x_q      <= sat_out(p10_x_q);
      y_q      <= sat_out(p10_y_q);
      z_q      <= sat_out(rnd(mul(p10_nb_q, p10_sl_q), 30));
    end
  end

  assign x_m_o = x_q;
  assign y_m_o = y_q;
  assign z_m_o = z_q;

endmodule

// ----- rtl/core/gte_checker.sv -----
// ----------------------------------------------------------------------------
// gte_checker
// Port-level checks on the geodetic to ECEF block, bound to its top level.
// ----------------------------------------------------------------------------
`include "geodetic_to_ecef_top_assert.svh"

module gte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] x_m_o,
  input logic signed [31:0] y_m_o,
  input logic signed [31:0] z_m_o
);
  import gte_pkg::*;

  logic held;

  assign held = out_valid_o && out_stall_i;

  // Input side only backs up when the output register is held.
  `GTE_ASSERT_NOW(a_in_stall_cause, in_stall_o, held)
  // A held result stays valid and unchanged.
  `GTE_ASSERT_NEXT(a_out_hold, held, out_valid_o && $stable({x_m_o, y_m_o, z_m_o}))
  // Results lie inside the saturation limits.
  `GTE_ASSERT_NOW(a_x_range, out_valid_o, x_m_o <= OUT_LIMIT && x_m_o >= -OUT_LIMIT)
  `GTE_ASSERT_NOW(a_y_range, out_valid_o, y_m_o <= OUT_LIMIT && y_m_o >= -OUT_LIMIT)
  `GTE_ASSERT_NOW(a_z_range, out_valid_o, z_m_o <= OUT_LIMIT && z_m_o >= -OUT_LIMIT)

endmodule

bind geodetic_to_ecef_top gte_checker u_gte_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for geodetic_to_ecef_top: geodetic points go in, ECEF X/Y/Z come out.
// A predictor built from plain fixed-point arithmetic computes X/Y/Z for each
// point the block takes in. Each result is checked against the oldest pending
// prediction. The sender runs in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC   = 24;
  localparam int unsigned STAGES = 28;
  localparam int unsigned LATENCY = STAGES + 15;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam longint FULL_TURN = 64'sd360 <<< FRAC;
  localparam longint HALF_TURN = 64'sd180 <<< FRAC;
  localparam longint QUARTER   = 64'sd90 <<< FRAC;
  localparam longint LON_MAX   = 64'sd3019898880;
  localparam longint LAT_MAX   = 64'sd1509949440;
  localparam longint OUT_LIM   = 64'sd1632803072;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } ecef_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic signed [32:0] lon_deg_i;
  logic signed [31:0] lat_deg_i;
  logic out_valid_o, out_stall_i;
  logic signed [31:0] x_m_o, y_m_o, z_m_o;

  ecef_t  pending_ecef[$];
  int     mismatch_cnt;
  int     idle_cycles;
  bit     stall_enable;

  geodetic_to_ecef_top #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Round-half-up right shift on a 64-bit signed value.
  function automatic longint rsh(longint v, int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_entry(int unsigned i);
    longint head[10];
    head = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
             64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // Rotation CORDIC: angle in degrees * 2^FRAC (within +-90), Q30 sine/cosine.
  function automatic void cordic_sin_cos(longint deg, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    z = rsh(deg * 64'sd74961321, FRAC + 2);
    x = 64'sd652032874;
    y = 0;
    for (int unsigned i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    sn = y;
    cs = x;
  endfunction

  function automatic logic signed [31:0] clamp_out(longint v);
    if (v > OUT_LIM) v = OUT_LIM;
    if (v < -OUT_LIM) v = -OUT_LIM;
    return v[31:0];
  endfunction

  function automatic ecef_t predict_ecef(logic signed [32:0] lon_in,
                                         logic signed [31:0] lat_in);
    longint lon, lat, slon, clon, slat, clat, s2, u, w, r, t, n8, c, nb;
    bit     flip;
    ecef_t  res;
    lon = lon_in;
    lat = lat_in;
    flip = 0;
    lon = lon % FULL_TURN;
    if (lon < 0) lon += FULL_TURN;
    if (lon >= HALF_TURN) lon -= FULL_TURN;
    if (lon > QUARTER) begin
      lon = HALF_TURN - lon; flip = 1;
    end else if (lon < -QUARTER) begin
      lon = -HALF_TURN - lon; flip = 1;
    end
    if (lat > QUARTER) lat = QUARTER;
    if (lat < -QUARTER) lat = -QUARTER;
    cordic_sin_cos(lon, slon, clon);
    if (flip) clon = -clon;
    cordic_sin_cos(lat, slat, clat);
    s2 = rsh(slat * slat, 30);
    u  = rsh(64'sd7188035 * s2, 30);
    w  = (64'sd1 <<< 30) - u;
    r  = (64'sd1 <<< 30) + (u >>> 1);
    // Two Newton steps for 1/sqrt(w)
    for (int k = 0; k < 2; k++) begin
      t = rsh(r * r, 30);
      t = rsh(w * t, 30);
      r = rsh(r * ((64'sd3 <<< 30) - t), 31);
    end
    n8 = rsh(64'sd6378137 * r, 22);
    c  = rsh(clat * clon, 30);
    res.x = clamp_out(rsh(n8 * c, 30));
    c  = rsh(clat * slon, 30);
    res.y = clamp_out(rsh(n8 * c, 30));
    nb = rsh(n8 * 64'sd1066553789, 30);
    res.z = clamp_out(rsh(nb * slat, 30));
    return res;
  endfunction

  // Drive one point; holds until the block takes it, then predicts.
  task automatic send_point(longint lon, longint lat);
    in_valid_i <= 1'b1;
    lon_deg_i  <= lon[32:0];
    lat_deg_i  <= lat[31:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_ecef.push_back(predict_ecef(lon[32:0], lat[31:0]));
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  // Extremes of both fields, wraps, folds and saturation.
  task automatic test_directed();
    longint lons[12];
    longint lats[6];
    lons = '{0, QUARTER, -QUARTER, QUARTER + 1, -QUARTER - 1, HALF_TURN, -HALF_TURN,
             FULL_TURN, LON_MAX, -LON_MAX, 64'sh0FFFFFFFF, -64'sh100000000};
    lats = '{0, QUARTER, -QUARTER, LAT_MAX, -LAT_MAX, 64'sd45 <<< FRAC};
    foreach (lons[i]) send_point(lons[i], lats[i % 6]);
    send_point(0, 64'sh7FFFFFFF);
    send_point(0, -64'sh80000000);
    send_point(-64'sh100000000, 64'sh7FFFFFFF);
    send_point(64'sh0FFFFFFFF, -64'sh80000000);
    in_valid_i <= 1'b0;
  endtask

  // Random points in bursts: mostly in range, some over full field width.
  task automatic test_random(int count);
    longint lon, lat;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      for (int b = 0; b < burst && count > 0; b++, count--) begin
        if ($urandom_range(0, 9) < 7) begin
          lon = longint'($urandom_range(0, 32'hFFFFFFFF)) % (2 * LON_MAX + 1) - LON_MAX;
          lat = longint'($urandom_range(0, 32'hFFFFFFFF)) % (2 * LAT_MAX + 1) - LAT_MAX;
        end else begin
          lon = {{31{1'b0}}, 1'($urandom), $urandom};
          lon = (lon <<< 31) >>> 31;
          lat = longint'(signed'($urandom));
        end
        send_point(lon, lat);
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    in_valid_i <= 1'b0;
  endtask

  // Receiver stall pattern: runs of stalls and free stretches.
  initial begin
    int run;
    out_stall_i = 1'b0;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) begin
        @(negedge clk_i);
        out_stall_i <= stall_enable && ($urandom_range(0, 2) == 0);
      end
      run = $urandom_range(5, 30);
      repeat (run) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker and watchdog, sampled at the rising edge.
  always @(posedge clk_i) begin
    ecef_t exp_v;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (pending_ecef.size() == 0) begin
          $display("%0t: result with no pending point: x=%0d y=%0d z=%0d",
                   $time, x_m_o, y_m_o, z_m_o);
          mismatch_cnt++;
        end else begin
          exp_v = pending_ecef.pop_front();
          if (exp_v.x !== x_m_o) begin
            $display("%0t: x_m expected %0d actual %0d", $time, exp_v.x, x_m_o);
            mismatch_cnt++;
          end
          if (exp_v.y !== y_m_o) begin
            $display("%0t: y_m expected %0d actual %0d", $time, exp_v.y, y_m_o);
            mismatch_cnt++;
          end
          if (exp_v.z !== z_m_o) begin
            $display("%0t: z_m expected %0d actual %0d", $time, exp_v.z, z_m_o);
            mismatch_cnt++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int drain;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    stall_enable = 1'b1;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    lon_deg_i    = '0;
    lat_deg_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(450);
    // Drain: stop stalling so the pipeline empties.
    stall_enable = 1'b0;
    drain = 0;
    while (pending_ecef.size() != 0 && drain < 20000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (LATENCY + 5) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_ecef.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
